FILE: rtl/saq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted arrival queue package
// Shared widths, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package saq_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 16;
  localparam int ID_WIDTH  = 16;
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic                 append;
    logic [KEY_WIDTH-1:0] new_key;
    logic [ID_WIDTH-1:0]  new_id;
  } saq_ctrl_t;

endpackage

FILE: rtl/saq_cell.sv
// ----------------------------------------------------------------------------
// Sorted arrival queue cell
// Holds one entry, compares it with the incoming key, and shifts toward the
// tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
module saq_cell (
  input  logic                          clk,
  input  saq_pkg::saq_ctrl_t            ctrl,
  input  logic                          occ,
  input  logic                          prev_match,
  input  logic                          hit_in,
  input  logic [saq_pkg::KEY_WIDTH-1:0] prev_key,
  input  logic [saq_pkg::ID_WIDTH-1:0]  prev_id,
  input  logic [saq_pkg::KEY_WIDTH-1:0] next_key,
  input  logic [saq_pkg::ID_WIDTH-1:0]  next_id,
  output logic                          match,
  output logic                          hit_out,
  output logic [saq_pkg::KEY_WIDTH-1:0] cell_key,
  output logic [saq_pkg::ID_WIDTH-1:0]  cell_id
);

  logic                          take_prev;
  logic                          take_new;
  logic [saq_pkg::KEY_WIDTH-1:0] cell_key_next;
  logic [saq_pkg::ID_WIDTH-1:0]  cell_id_next;

  // An entry matches when it is stored and the request is an append or its key does not exceed the new key.
  assign match     = occ && (ctrl.append || (cell_key <= ctrl.new_key));
  assign hit_out   = match || hit_in;
  assign take_prev = !hit_out && !prev_match;
  assign take_new  = !hit_out && prev_match;

  always_comb begin
    cell_key_next = cell_key;
    cell_id_next  = cell_id;
    unique case (ctrl.op)
      saq_pkg::OP_INSERT: begin
        if (take_prev) begin
          cell_key_next = prev_key;
          cell_id_next  = prev_id;
        end else if (take_new) begin
          cell_key_next = ctrl.new_key;
          cell_id_next  = ctrl.new_id;
        end
      end
      saq_pkg::OP_POP: begin
        cell_key_next = next_key;
        cell_id_next  = next_id;
      end
      default: begin
        cell_key_next = cell_key;
        cell_id_next  = cell_id;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cell_key <= cell_key_next;
    cell_id  <= cell_id_next;
  end

endmodule

FILE: rtl/sorted_arrival_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted arrival queue core
// Bounded queue of (id, key) entries held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// For each request, every cell compares its key with the incoming key in
// parallel, the insert position ripples through the row as a single match
// bit, and the cells that move shift by one place at the same clock edge.
// A new request is taken every cycle while the result register is empty or is
// being drained, so the sustained rate is one request per cycle. A sorted
// insert goes after the last stored entry whose key is less than or equal to
// the new key, an append goes to the tail, and a pop returns the head entry.
// Every request produces exactly one result carrying the status and the count
// of stored entries after the request.
module sorted_arrival_queue_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    cmd,
  input  logic [saq_pkg::ID_WIDTH-1:0]  item_id,
  input  logic [saq_pkg::KEY_WIDTH-1:0] key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [saq_pkg::ID_WIDTH-1:0]  out_id,
  output logic [saq_pkg::KEY_WIDTH-1:0] out_key,
  output logic [saq_pkg::CNT_WIDTH-1:0] count
);

  logic                          in_fire;
  logic                          is_add;
  logic                          is_pop;
  logic                          full;
  logic                          empty;
  logic [saq_pkg::CNT_WIDTH-1:0] fill_count;
  logic [saq_pkg::CNT_WIDTH-1:0] fill_count_next;
  logic [1:0]                    status_next;
  logic [saq_pkg::ID_WIDTH-1:0]  out_id_next;
  logic [saq_pkg::KEY_WIDTH-1:0] out_key_next;
  logic                          out_valid_next;
  saq_pkg::saq_ctrl_t            ctrl;

  logic [saq_pkg::KEY_WIDTH-1:0] cell_key [saq_pkg::DEPTH];
  logic [saq_pkg::ID_WIDTH-1:0]  cell_id  [saq_pkg::DEPTH];
  logic [saq_pkg::DEPTH-1:0]     occ;
  logic [saq_pkg::DEPTH-1:0]     match;
  logic [saq_pkg::DEPTH:0]       hit;

  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign is_add   = (cmd == saq_pkg::CMD_INSERT) || (cmd == saq_pkg::CMD_APPEND);
  assign is_pop   = (cmd == saq_pkg::CMD_POP);
  assign full     = (fill_count == saq_pkg::CNT_WIDTH'(saq_pkg::DEPTH));
  assign empty    = (fill_count == '0);

  always_comb begin
    ctrl.op      = saq_pkg::OP_HOLD;
    ctrl.append  = (cmd == saq_pkg::CMD_APPEND);
    ctrl.new_key = key;
    ctrl.new_id  = item_id;
    if (in_fire && is_add && !full) begin
      ctrl.op = saq_pkg::OP_INSERT;
    end else if (in_fire && is_pop && !empty) begin
      ctrl.op = saq_pkg::OP_POP;
    end
  end

  assign hit[saq_pkg::DEPTH] = 1'b0;

  for (genvar i = 0; i < saq_pkg::DEPTH; i++) begin : g_cell
    assign occ[i] = (saq_pkg::CNT_WIDTH'(i) < fill_count);

    saq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ[i]),
      .prev_match ((i == 0) ? 1'b1 : match[(i == 0) ? 0 : i - 1]),
      .hit_in     (hit[i + 1]),
      .prev_key   (cell_key[(i == 0) ? 0 : i - 1]),
      .prev_id    (cell_id[(i == 0) ? 0 : i - 1]),
      .next_key   (cell_key[(i == saq_pkg::DEPTH - 1) ? i : i + 1]),
      .next_id    (cell_id[(i == saq_pkg::DEPTH - 1) ? i : i + 1]),
      .match      (match[i]),
      .hit_out    (hit[i]),
      .cell_key   (cell_key[i]),
      .cell_id    (cell_id[i])
    );
  end

  always_comb begin
    fill_count_next = fill_count;
    status_next     = saq_pkg::ST_DONE;
    out_id_next     = '0;
    out_key_next    = '0;
    if (is_add) begin
      if (full) begin
        status_next = saq_pkg::ST_FULL;
      end else begin
        fill_count_next = fill_count + 1'b1;
      end
    end else if (is_pop) begin
      if (empty) begin
        status_next = saq_pkg::ST_EMPTY;
      end else begin
        out_id_next     = cell_id[0];
        out_key_next    = cell_key[0];
        fill_count_next = fill_count - 1'b1;
      end
    end
  end

  assign out_valid_next = in_fire || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (in_fire) begin
        fill_count <= fill_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status  <= status_next;
      out_id  <= out_id_next;
      out_key <= out_key_next;
      count   <= fill_count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= saq_pkg::CNT_WIDTH'(saq_pkg::DEPTH))
    else $error("Fill count exceeds the queue depth.");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == saq_pkg::ST_FULL) |->
      (count == saq_pkg::CNT_WIDTH'(saq_pkg::DEPTH)))
    else $error("Full status reported while the queue has room.");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == saq_pkg::ST_EMPTY) |->
      (count == '0) && (out_key == '0) && (out_id == '0))
    else $error("Empty status reported with stored entries or data.");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_pop && !empty |=>
      (fill_count + 1'b1 == $past(fill_count)))
    else $error("Pop did not remove exactly one entry.");

endmodule

FILE: bench/saq_checker.sv
// ----------------------------------------------------------------------------
// Sorted arrival queue checker
// Watches the request and result channels of the queue core, keeps its own copy of the
// queue contents, predicts one result for every accepted request and compares
// every accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module saq_checker
  import saq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic [ID_WIDTH-1:0]  item_id,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           status,
  input  logic [ID_WIDTH-1:0]  out_id,
  input  logic [KEY_WIDTH-1:0] out_key,
  input  logic [CNT_WIDTH-1:0] count,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct {
    logic [1:0]           status;
    logic [ID_WIDTH-1:0]  id;
    logic [KEY_WIDTH-1:0] key;
    logic [CNT_WIDTH-1:0] count;
  } saq_result_t;

  saq_result_t          pending_results[$];
  logic [KEY_WIDTH-1:0] queue_keys[DEPTH];
  logic [ID_WIDTH-1:0]  queue_ids[DEPTH];
  int                   queue_fill;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic saq_result_t apply_request(input logic [1:0] op,
                                                input logic [ID_WIDTH-1:0] new_id,
                                                input logic [KEY_WIDTH-1:0] new_key);
    saq_result_t r;
    int          slot;
    r.status = ST_DONE;
    r.id     = '0;
    r.key    = '0;
    if (op == CMD_INSERT || op == CMD_APPEND) begin
      if (queue_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot = queue_fill;
        if (op == CMD_INSERT) begin
          slot = 0;
          for (int i = 0; i < queue_fill; i++) begin
            if (queue_keys[i] <= new_key) slot = i + 1;
          end
        end
        for (int i = queue_fill; i > slot; i--) begin
          queue_keys[i] = queue_keys[i-1];
          queue_ids[i]  = queue_ids[i-1];
        end
        queue_keys[slot] = new_key;
        queue_ids[slot]  = new_id;
        queue_fill++;
      end
    end else if (op == CMD_POP) begin
      if (queue_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.id  = queue_ids[0];
        r.key = queue_keys[0];
        for (int i = 1; i < queue_fill; i++) begin
          queue_keys[i-1] = queue_keys[i];
          queue_ids[i-1]  = queue_ids[i];
        end
        queue_fill--;
      end
    end
    r.count = queue_fill[CNT_WIDTH-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    saq_result_t want;
    if (rst) begin
      queue_fill = 0;
      pending_results.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status, want.status));
          if (out_id !== want.id)
            report_mismatch($sformatf("out_id got %h want %h", out_id, want.id));
          if (out_key !== want.key)
            report_mismatch($sformatf("out_key got %h want %h", out_key, want.key));
          if (count !== want.count)
            report_mismatch($sformatf("count got %0d want %0d", count, want.count));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        pending_results.push_back(apply_request(cmd, item_id, key));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: bench/tb_sorted_arrival_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted arrival queue core testbench
// Drives directed and random insert, append, pop and unused requests with
// bursty input and a patterned output stall, including long hold-offs that
// back the queue up, and reports the checker's verdict at the end.
// ----------------------------------------------------------------------------
module tb_sorted_arrival_queue_core;
  import saq_pkg::*;

  localparam logic [1:0] CMD_UNUSED      = 2'd3;
  localparam int         RANDOM_REQUESTS = 1530;
  localparam int         HOLD_CYCLES     = 80;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           cmd;
  logic [ID_WIDTH-1:0]  item_id;
  logic [KEY_WIDTH-1:0] key;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           status;
  logic [ID_WIDTH-1:0]  out_id;
  logic [KEY_WIDTH-1:0] out_key;
  logic [CNT_WIDTH-1:0] count;

  int mismatches;
  int outstanding;
  int requests_sent;
  int burst_left;
  bit steady;

  sorted_arrival_queue_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .item_id   (item_id),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .out_id    (out_id),
    .out_key   (out_key),
    .count     (count)
  );

  saq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .item_id     (item_id),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_id      (out_id),
    .out_key     (out_key),
    .count       (count),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_request(input logic [1:0] op, input logic [ID_WIDTH-1:0] new_id,
                              input logic [KEY_WIDTH-1:0] new_key);
    @(negedge clk);
    in_valid <= 1'b1;
    cmd      <= op;
    item_id  <= new_id;
    key      <= new_key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (!steady && $urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
  endtask

  function automatic logic [KEY_WIDTH-1:0] pick_key();
    logic [KEY_WIDTH-1:0] k;
    case ($urandom_range(0, 3))
      0: k = KEY_WIDTH'($urandom_range(0, 7));
      1: k = KEY_WIDTH'($urandom_range(100, 110));
      2: k = ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: k = KEY_WIDTH'($urandom);
    endcase
    return k;
  endfunction

  // Receiver: stall pattern in segments, plus two long hold-offs.
  initial begin
    int mode;
    int hold_stage;
    out_stall  = 1'b0;
    hold_stage = 0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 100)) begin
        @(negedge clk);
        if (hold_stage < 2 && requests_sent >= (hold_stage + 1) * 600) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_stage++;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  initial begin
    int mode;
    int pick;
    int sent;
    logic [1:0] op;
    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = CMD_INSERT;
    item_id       = '0;
    key           = '0;
    requests_sent = 0;
    burst_left    = 0;
    steady        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty queue, ties, head and tail inserts, unsorted contents, drain.
    send_request(CMD_POP,    16'hFFFF, 16'hFFFF);
    send_request(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
    send_request(CMD_INSERT, 16'h0001, 16'd100);
    send_request(CMD_INSERT, 16'h0002, 16'd100);
    send_request(CMD_INSERT, 16'h0003, 16'h0000);
    send_request(CMD_INSERT, 16'h0004, 16'hFFFF);
    send_request(CMD_APPEND, 16'h0005, 16'd50);
    send_request(CMD_INSERT, 16'h0006, 16'd60);
    send_request(CMD_INSERT, 16'h0007, 16'd100);
    send_request(CMD_UNUSED, 16'hA5A5, 16'h5A5A);
    send_request(CMD_POP,    16'hFFFF, 16'hFFFF);
    send_request(CMD_APPEND, 16'hFFFF, 16'h0000);
    repeat (8) send_request(CMD_POP, 16'h0000, 16'h0000);
    send_request(CMD_POP, 16'h1234, 16'h4321);

    // Random segments biased toward filling, draining or mixed traffic.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      mode   = $urandom_range(0, 2);
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(10, 50)) begin
        pick = $urandom_range(0, 99);
        case (mode)
          0: op = (pick < 60) ? CMD_INSERT : (pick < 85) ? CMD_APPEND :
                  (pick < 97) ? CMD_POP : CMD_UNUSED;
          1: op = (pick < 20) ? CMD_INSERT : (pick < 30) ? CMD_APPEND :
                  (pick < 97) ? CMD_POP : CMD_UNUSED;
          default: op = (pick < 35) ? CMD_INSERT : (pick < 55) ? CMD_APPEND :
                        (pick < 97) ? CMD_POP : CMD_UNUSED;
        endcase
        send_request(op, ID_WIDTH'($urandom), pick_key());
        sent++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
